### design/pbs_pkg.sv
// pbs_pkg: shared types, constants and the back-end state type for the partial bubble sort core
// depends on nothing; the front, queue, back end, top level and checker refer to it by scoped names
`default_nettype none

package pbs_pkg;

	// defaults for the top level parameters
	localparam int MAX_LEN_DEF     = 64;
	localparam int VALUE_WIDTH_DEF = 32;

	// fixed field widths of the item and result transfers
	localparam int VALUE_FIELD_W = 32;
	localparam int PASS_FIELD_W  = 16;

	// element counts and pass counts; wide enough for any MAX_LEN up to 127 (the default is 64)
	localparam int CNT_W = 7;

	// list buffers in the element memory, one per job slot of the queue
	localparam int NUM_BANKS = 2;

	typedef struct packed {
		logic [VALUE_FIELD_W-1:0] value;
		logic                     is_last;
		logic [PASS_FIELD_W-1:0]  pass_count;
	} item_t;

	typedef struct packed {
		logic [VALUE_FIELD_W-1:0] value_res;
		logic                     is_last_res;
		logic                     overflow;
	} res_t;

	// one loaded list waiting for the back end
	typedef struct packed {
		logic [CNT_W-1:0] len;
		logic [CNT_W-1:0] passes;
		logic             ovf;
	} job_t;

	// queue status seen by the front and back ends
	typedef struct packed {
		logic full;
		logic empty;
	} jobq_stat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ISSUE,
		BK_DRAIN
	} back_state_t;

endpackage

`default_nettype wire

### design/pbs_ram.sv
// pbs_ram: generic single-write, single-read memory with registered read data
// depends on nothing
`default_nettype none

module pbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### design/pbs_front.sv
// pbs_front: takes item transfers, stores elements into the current bank and builds the job
// depends on pbs_pkg
`default_nettype none

module pbs_front #(
	parameter int MAX_LEN     = pbs_pkg::MAX_LEN_DEF,
	parameter int VALUE_WIDTH = pbs_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               accept,
	input  wire pbs_pkg::item_t                     item,
	output logic                                    we,
	output logic [$clog2(MAX_LEN)+$clog2(pbs_pkg::NUM_BANKS)-1:0] waddr,
	output logic [VALUE_WIDTH-1:0]                  wdata,
	output logic                                    push,
	output pbs_pkg::job_t                           push_job
);

	localparam int IDX_W  = $clog2(MAX_LEN);
	localparam int BANK_W = $clog2(pbs_pkg::NUM_BANKS);
	localparam int CW     = pbs_pkg::CNT_W;
	localparam int PW     = pbs_pkg::PASS_FIELD_W;

	logic [CW-1:0]     count_q;
	logic              ovf_q;
	logic [BANK_W-1:0] bank_q;
	logic              has_room;
	logic [CW-1:0]     len_new;

	assign has_room = count_q < CW'(MAX_LEN);
	assign len_new  = has_room ? count_q + CW'(1) : count_q;

	assign we    = accept && has_room;
	assign waddr = {bank_q, count_q[IDX_W-1:0]};
	assign wdata = VALUE_WIDTH'(item.value);

	assign push            = accept && item.is_last;
	assign push_job.len    = len_new;
	assign push_job.passes = (item.pass_count < PW'(len_new)) ? CW'(item.pass_count) : len_new;
	assign push_job.ovf    = ovf_q || !has_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			bank_q  <= '0;
		end else if (push) begin
			// list complete: restart counting in the other bank
			count_q <= '0;
			ovf_q   <= 1'b0;
			bank_q  <= bank_q + BANK_W'(1);
		end else if (accept) begin
			count_q <= len_new;
			ovf_q   <= ovf_q || !has_room;
		end
	end

endmodule

`default_nettype wire

### design/pbs_jobq.sv
// pbs_jobq: two-entry queue of loaded lists between the front and back ends
// depends on pbs_pkg
`default_nettype none

module pbs_jobq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire pbs_pkg::job_t       push_job,
	input  wire logic                pop,
	output pbs_pkg::job_t            head,
	output pbs_pkg::jobq_stat_t      stat
);

	localparam int PTR_W = $clog2(pbs_pkg::NUM_BANKS);
	localparam int CNT_W = $clog2(pbs_pkg::NUM_BANKS + 1);

	pbs_pkg::job_t    slot_q [pbs_pkg::NUM_BANKS];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign head       = slot_q[rd_q];
	assign stat.full  = cnt_q == CNT_W'(pbs_pkg::NUM_BANKS);
	assign stat.empty = cnt_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

### design/pbs_cell.sv
// pbs_cell: one bubble pass as a streaming min/max cell; keeps the running maximum
// depends on nothing
`default_nettype none

module pbs_cell #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   active,
	input  wire logic                   in_v,
	input  wire logic                   in_f,
	input  wire logic [VALUE_WIDTH-1:0] in_d,
	output logic                        out_v,
	output logic                        out_f,
	output logic [VALUE_WIDTH-1:0]      out_d
);

	logic                   full_q;
	logic [VALUE_WIDTH-1:0] held_q;
	logic                   lt;
	logic                   full_d;
	logic                   v_d;
	logic                   f_d;
	logic [VALUE_WIDTH-1:0] d_d;
	logic [VALUE_WIDTH-1:0] held_d;

	assign lt = in_d < held_q;

	always_comb begin
		full_d = full_q;
		held_d = held_q;
		v_d    = 1'b0;
		f_d    = 1'b0;
		d_d    = in_d;
		if (!active) begin
			v_d = in_v;
			f_d = in_f;
		end else if (in_v && !in_f) begin
			if (full_q) begin
				// emit the smaller, keep the larger
				v_d    = 1'b1;
				d_d    = lt ? in_d : held_q;
				held_d = lt ? held_q : in_d;
			end else begin
				full_d = 1'b1;
				held_d = in_d;
			end
		end else if (in_v) begin
			if (full_q) begin
				// end of list: the held maximum takes the flush slot
				v_d    = 1'b1;
				d_d    = held_q;
				full_d = 1'b0;
			end else begin
				v_d = 1'b1;
				f_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			out_v  <= 1'b0;
		end else begin
			full_q <= full_d;
			out_v  <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		held_q <= held_d;
		out_f  <= f_d;
		out_d  <= d_d;
	end

endmodule

`default_nettype wire

### design/pbs_back.sv
// pbs_back: replays a queued list from memory through the chain of pass cells and emits results
// depends on pbs_pkg and pbs_cell
`default_nettype none

module pbs_back #(
	parameter int MAX_LEN     = pbs_pkg::MAX_LEN_DEF,
	parameter int VALUE_WIDTH = pbs_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire pbs_pkg::job_t                      head,
	input  wire pbs_pkg::jobq_stat_t                qstat,
	output logic                                    pop,
	output logic [$clog2(MAX_LEN)+$clog2(pbs_pkg::NUM_BANKS)-1:0] raddr,
	input  wire logic [VALUE_WIDTH-1:0]             rdata,
	output logic                                    result_valid,
	output pbs_pkg::res_t                           result
);

	localparam int IDX_W  = $clog2(MAX_LEN);
	localparam int BANK_W = $clog2(pbs_pkg::NUM_BANKS);
	localparam int CW     = pbs_pkg::CNT_W;
	localparam int RVW    = pbs_pkg::VALUE_FIELD_W;

	pbs_pkg::back_state_t state_q, state_d;

	logic [CW-1:0]      len_q;
	logic [CW-1:0]      passes_q;
	logic               ovf_q;
	logic [BANK_W-1:0]  bank_q;
	logic [CW:0]        issue_q;
	logic [CW-1:0]      out_cnt_q;
	logic [MAX_LEN-1:0] active_q;
	logic               tv_s1;
	logic               tf_s1;
	logic               load;
	logic               issuing;
	logic               issue_end;
	logic               done;

	logic               tok_v [MAX_LEN+1];
	logic               tok_f [MAX_LEN+1];
	logic [VALUE_WIDTH-1:0] tok_d [MAX_LEN+1];

	assign issue_end = issue_q == ({1'b0, len_q} + {1'b0, passes_q} - (CW+1)'(1));
	assign raddr     = {bank_q, issue_q[IDX_W-1:0]};

	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		issuing = 1'b0;
		unique case (state_q)
			pbs_pkg::BK_IDLE: begin
				if (!qstat.empty) begin
					load    = 1'b1;
					state_d = pbs_pkg::BK_ISSUE;
				end
			end
			pbs_pkg::BK_ISSUE: begin
				issuing = 1'b1;
				if (issue_end) begin
					state_d = pbs_pkg::BK_DRAIN;
				end
			end
			pbs_pkg::BK_DRAIN: begin
				if (done) begin
					state_d = pbs_pkg::BK_IDLE;
				end
			end
			default: state_d = pbs_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbs_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q    <= '0;
			issue_q   <= '0;
			out_cnt_q <= '0;
			active_q  <= '0;
			tv_s1     <= 1'b0;
		end else begin
			tv_s1 <= issuing;
			if (load) begin
				issue_q   <= '0;
				out_cnt_q <= '0;
				for (int j = 0; j < MAX_LEN; j++) begin
					active_q[j] <= CW'(j) < head.passes;
				end
			end else begin
				if (issuing) begin
					issue_q <= issue_q + (CW+1)'(1);
				end
				if (tok_v[MAX_LEN]) begin
					out_cnt_q <= out_cnt_q + CW'(1);
				end
			end
			if (done) begin
				bank_q <= bank_q + BANK_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			len_q    <= head.len;
			passes_q <= head.passes;
			ovf_q    <= head.ovf;
		end
		// past the stored elements the slots carry flush marks
		tf_s1 <= issue_q >= {1'b0, len_q};
	end

	assign tok_v[0] = tv_s1;
	assign tok_f[0] = tf_s1;
	assign tok_d[0] = rdata;

	for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
		pbs_cell #(
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.active (active_q[j]),
			.in_v   (tok_v[j]),
			.in_f   (tok_f[j]),
			.in_d   (tok_d[j]),
			.out_v  (tok_v[j+1]),
			.out_f  (tok_f[j+1]),
			.out_d  (tok_d[j+1])
		);
	end

	// every flush is absorbed by an active cell, so the chain end only shows elements
	assign done = tok_v[MAX_LEN] && (out_cnt_q == len_q - CW'(1));
	assign pop  = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= tok_v[MAX_LEN];
		end
	end

	always_ff @(posedge clk) begin
		result.value_res   <= RVW'(tok_d[MAX_LEN]);
		result.is_last_res <= out_cnt_q == len_q - CW'(1);
		result.overflow    <= ovf_q;
	end

endmodule

`default_nettype wire

### design/partial_bubble_sort_core.sv
// one list occupies the back end from its memory replay until it has drained out of the cell chain
// loading takes one item per cycle; busy only while both list buffers hold unfinished lists
// results come one per cycle at most, never stalled; reset clears all control, memory is left as is
// partial_bubble_sort_core: top level; depends on pbs_pkg, pbs_ram, pbs_front, pbs_jobq, pbs_back
`default_nettype none

module partial_bubble_sort_core #(
	parameter int MAX_LEN     = pbs_pkg::MAX_LEN_DEF,
	parameter int VALUE_WIDTH = pbs_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire pbs_pkg::item_t item,
	output logic                result_valid,
	output pbs_pkg::res_t       result
);

	// element memory holds two list buffers, addressed by {bank, position}
	localparam int IDX_W  = $clog2(MAX_LEN);
	localparam int BANK_W = $clog2(pbs_pkg::NUM_BANKS);
	localparam int ADDR_W = IDX_W + BANK_W;
	localparam int DEPTH  = pbs_pkg::NUM_BANKS * (2 ** IDX_W);

	logic                     accept;
	logic                     we;
	logic [ADDR_W-1:0]        waddr;
	logic [VALUE_WIDTH-1:0]   wdata;
	logic [ADDR_W-1:0]        raddr;
	logic [VALUE_WIDTH-1:0]   rdata;
	logic                     push;
	logic                     pop;
	pbs_pkg::job_t            push_job;
	pbs_pkg::job_t            head;
	pbs_pkg::jobq_stat_t      qstat;

	// an item transfer completes when start meets a free front end
	assign accept = start && !busy;

	// the front end stalls only when no list buffer is free
	assign busy = qstat.full;

	// front: stores each element that fits and, on the last one, queues length, capped passes and overflow
	pbs_front #(
		.MAX_LEN     (MAX_LEN),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata),
		.push     (push),
		.push_job (push_job)
	);

	// queue of finished lists; its depth equals the number of list buffers
	pbs_jobq u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	pbs_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// back: replays the list, then flush marks, through one min/max cell per pass
	pbs_back #(
		.MAX_LEN     (MAX_LEN),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.raddr        (raddr),
		.rdata        (rdata),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire

### design/pbs_chk.sv
// pbs_chk: port-level checks of the partial bubble sort core, bound to the top level
// depends on pbs_pkg and partial_bubble_sort_core
`default_nettype none

module pbs_chk (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire pbs_pkg::item_t item,
	input wire logic           result_valid,
	input wire pbs_pkg::res_t  result
);

	// lists whose last item was taken but whose last result has not been shown
	logic [1:0] pending_q;
	logic       list_in;
	logic       list_out;

	assign list_in  = start && !busy && item.is_last;
	assign list_out = result_valid && result.is_last_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (list_in && !list_out) begin
			pending_q <= pending_q + 2'd1;
		end else if (list_out && !list_in) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose without a preceding item transfer");

	a_result_needs_list: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != 2'd0)
		else $error("result shown with no list outstanding");

	a_busy_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> pending_q == 2'd2)
		else $error("busy while a list buffer is free");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more lists outstanding than buffers");

endmodule

bind partial_bubble_sort_core pbs_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.item         (item),
	.result_valid (result_valid),
	.result       (result)
);

`default_nettype wire
